[design/length_prefixed_frame_deframer_defines.svh]
// Assertion macros shared by the deframer modules.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LPFD_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/lpfd_pkg.sv]
`default_nettype none

package lpfd_pkg;

   localparam int INDEX_BYTES = 4;
   localparam int HDR_LEN     = INDEX_BYTES + 3;
   localparam int LEN_POS     = INDEX_BYTES;
   localparam int CMD_POS     = INDEX_BYTES + 2;

   localparam logic [7:0] NL_BYTE = 8'h0A;

   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [1:0] CSR_MIN_DATA_LEN = 2'd0;
   localparam logic [1:0] CSR_MAX_DATA_LEN = 2'd1;
   localparam logic [1:0] CSR_CMD_MIN      = 2'd2;
   localparam logic [1:0] CSR_CMD_MAX      = 2'd3;

   localparam logic [15:0] MIN_DATA_LEN_RESET = 16'd2;
   localparam logic [15:0] MAX_DATA_LEN_RESET = 16'd1026;
   localparam logic [7:0]  CMD_MIN_RESET      = 8'd0;
   localparam logic [7:0]  CMD_MAX_RESET      = 8'd255;

   // Most result items that one input item can produce.
   localparam int RSP_SLOTS = 3;
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_HUNT  = 3'b001,
      MODE_BODY  = 3'b010,
      MODE_AFTER = 3'b100
   } mode_type;

   typedef logic [HDR_LEN-1:0][7:0] window_type;

   typedef struct packed {
      logic [15:0] min_data_len;
      logic [15:0] max_data_len;
      logic [7:0]  cmd_min;
      logic [7:0]  cmd_max;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        first;
      logic        last;
      logic [31:0] frame_index;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]                        num;
      rsp_item_type [RSP_SLOTS-1:0]      item;
   } push_type;

endpackage

`default_nettype wire

[design/lpfd_parser.sv]
`default_nettype none
`include "length_prefixed_frame_deframer_defines.svh"

module lpfd_parser #(
   parameter int CRC_BYTES = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic              op,
   input  wire logic [7:0]        data_byte,
   input  wire lpfd_pkg::cfg_type cfg,
   output lpfd_pkg::push_type     push
);

   lpfd_pkg::window_type win_ff, win_in;
   logic [2:0]           fill_ff, fill_in;
   logic [16:0]          rem_ff, rem_in;
   lpfd_pkg::mode_type   mode_ff, mode_in;
   logic [31:0]          index_ff, index_in;

   lpfd_pkg::window_type win0, win1, win2;
   logic [2:0]           fill0, fill1, fill2;
   logic                 full, hdr_ok, do_hunt;
   logic [15:0]          acc_len;
   logic [16:0]          acc_rem, rem_dec;
   logic [31:0]          acc_index;

   function automatic logic len_ok(input logic [7:0] hi, input logic [7:0] lo,
                                   input lpfd_pkg::cfg_type c);
      logic [15:0] len;
      len = {hi, lo};
      return (len != 16'd0) && (len >= c.min_data_len) && (len <= c.max_data_len);
   endfunction

   function automatic logic cmd_ok(input logic [7:0] cmd, input lpfd_pkg::cfg_type c);
      return (cmd >= c.cmd_min) && (cmd <= c.cmd_max);
   endfunction

   // Window resync: at most two slides can follow one new byte, a failed full
   // header and then a failed length check on the shifted bytes.
   always_comb begin
      win0 = win_ff;
      if (fill_ff < 3'(lpfd_pkg::HDR_LEN)) begin
         win0[fill_ff] = data_byte;
      end
      fill0 = fill_ff + 3'd1;
      full  = (fill0 == 3'(lpfd_pkg::HDR_LEN));
      hdr_ok = full
         && len_ok(win0[lpfd_pkg::LEN_POS], win0[lpfd_pkg::LEN_POS+1], cfg)
         && cmd_ok(win0[lpfd_pkg::CMD_POS], cfg);
      if (full) begin
         win1  = lpfd_pkg::window_type'(win0 >> 8);
         fill1 = 3'(lpfd_pkg::HDR_LEN - 1);
      end else begin
         win1  = win0;
         fill1 = fill0;
      end
      if (fill1 == 3'(lpfd_pkg::HDR_LEN - 1)
          && !len_ok(win1[lpfd_pkg::LEN_POS], win1[lpfd_pkg::LEN_POS+1], cfg)) begin
         win2  = lpfd_pkg::window_type'(win1 >> 8);
         fill2 = fill1 - 3'd1;
      end else begin
         win2  = win1;
         fill2 = fill1;
      end
      acc_len   = {win0[lpfd_pkg::LEN_POS], win0[lpfd_pkg::LEN_POS+1]};
      acc_rem   = 17'(acc_len) - 17'd1 + 17'(CRC_BYTES);
      acc_index = {win0[0], win0[1], win0[2], win0[3]};
      rem_dec   = (rem_ff != 17'd0) ? rem_ff - 17'd1 : rem_ff;
   end

   always_comb begin
      win_in   = win_ff;
      fill_in  = fill_ff;
      rem_in   = rem_ff;
      mode_in  = mode_ff;
      index_in = index_ff;
      push     = '0;
      do_hunt  = 1'b0;
      if (step) begin
         if (op == lpfd_pkg::OP_CLEAR) begin
            win_in   = '0;
            fill_in  = 3'd0;
            rem_in   = 17'd0;
            mode_in  = lpfd_pkg::MODE_HUNT;
            index_in = 32'd0;
         end else begin
            unique case (mode_ff)
               lpfd_pkg::MODE_BODY: begin
                  rem_in                    = rem_dec;
                  push.num                  = 2'd1;
                  push.item[0].out_byte     = data_byte;
                  push.item[0].first        = 1'b0;
                  push.item[0].last         = (rem_dec == 17'd0);
                  push.item[0].frame_index  = index_ff;
                  mode_in = (rem_dec == 17'd0) ? lpfd_pkg::MODE_AFTER : lpfd_pkg::MODE_BODY;
               end
               lpfd_pkg::MODE_AFTER: begin
                  // A single newline right after a frame is swallowed.
                  mode_in = lpfd_pkg::MODE_HUNT;
                  do_hunt = (data_byte != lpfd_pkg::NL_BYTE);
               end
               default: begin
                  do_hunt = 1'b1;
               end
            endcase
         end
      end
      if (do_hunt) begin
         if (hdr_ok) begin
            index_in = acc_index;
            rem_in   = acc_rem;
            push.num = 2'd3;
            push.item[0].out_byte    = win0[lpfd_pkg::LEN_POS];
            push.item[0].first       = 1'b1;
            push.item[0].last        = 1'b0;
            push.item[0].frame_index = acc_index;
            push.item[1].out_byte    = win0[lpfd_pkg::LEN_POS+1];
            push.item[1].first       = 1'b0;
            push.item[1].last        = 1'b0;
            push.item[1].frame_index = acc_index;
            push.item[2].out_byte    = win0[lpfd_pkg::CMD_POS];
            push.item[2].first       = 1'b0;
            push.item[2].last        = (acc_rem == 17'd0);
            push.item[2].frame_index = acc_index;
            mode_in = (acc_rem == 17'd0) ? lpfd_pkg::MODE_AFTER : lpfd_pkg::MODE_BODY;
            win_in  = '0;
            fill_in = 3'd0;
         end else begin
            win_in  = win2;
            fill_in = fill2;
            mode_in = lpfd_pkg::MODE_HUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         fill_ff  <= 3'd0;
         rem_ff   <= 17'd0;
         mode_ff  <= lpfd_pkg::MODE_HUNT;
         index_ff <= 32'd0;
      end else begin
         win_ff   <= win_in;
         fill_ff  <= fill_in;
         rem_ff   <= rem_in;
         mode_ff  <= mode_in;
         index_ff <= index_in;
      end
   end

   `LPFD_ASSERT_HOLDS(a_fill_bound, clock, reset, 1'b1, fill_ff < 3'(lpfd_pkg::HDR_LEN), "header window overfilled")
   `LPFD_ASSERT_HOLDS(a_body_count, clock, reset, mode_ff == lpfd_pkg::MODE_BODY, rem_ff != 17'd0, "body mode with nothing left")
   `LPFD_ASSERT_NEXT(a_accept_empties, clock, reset, push.num == 2'd3, fill_ff == 3'd0, "window not emptied after header")

endmodule

`default_nettype wire

[design/lpfd_rsp_fifo.sv]
`default_nettype none
`include "length_prefixed_frame_deframer_defines.svh"

module lpfd_rsp_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lpfd_pkg::push_type     push,
   input  wire logic                   pop,
   output lpfd_pkg::rsp_item_type      head,
   output logic                        not_empty,
   output logic                        has_room
);

   lpfd_pkg::rsp_item_type            mem_ff [lpfd_pkg::RSP_DEPTH];
   logic [lpfd_pkg::RSP_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lpfd_pkg::RSP_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lpfd_pkg::RSP_CNT_W-1:0]    count_ff, count_in;

   assign not_empty = (count_ff != '0);
   // Room for the largest burst, without counting on a pop this cycle.
   assign has_room  = (count_ff <= lpfd_pkg::RSP_CNT_W'(lpfd_pkg::RSP_DEPTH - lpfd_pkg::RSP_SLOTS));
   assign head      = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + lpfd_pkg::RSP_PTR_W'(push.num);
   assign rd_ptr_in = rd_ptr_ff + lpfd_pkg::RSP_PTR_W'(pop);
   assign count_in  = count_ff + lpfd_pkg::RSP_CNT_W'(push.num) - lpfd_pkg::RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int k = 0; k < lpfd_pkg::RSP_SLOTS; k++) begin
         if (2'(k) < push.num) begin
            mem_ff[wr_ptr_ff + lpfd_pkg::RSP_PTR_W'(k)] <= push.item[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `LPFD_ASSERT_HOLDS(a_no_overflow, clock, reset, push.num != 2'd0, (5'(count_ff) + 5'(push.num)) <= 5'(lpfd_pkg::RSP_DEPTH), "result queue overflow")
   `LPFD_ASSERT_NEXT(a_count_grows, clock, reset, push.num != 2'd0 && !pop, count_ff == $past(count_ff) + lpfd_pkg::RSP_CNT_W'($past(push.num)), "result count lost a push")

endmodule

`default_nettype wire

[design/length_prefixed_frame_deframer.sv]
// Length-prefixed frame deframer.
// The req channel carries one stream byte per item (req_op low) or a clear
// command (req_op high) that returns the parser to hunting and drops any
// partial header or frame. The rsp channel returns frame bytes from the length
// high byte through the last CRC byte, with rsp_first on the length high byte,
// rsp_last on the final byte and the frame's 32-bit index on every byte.
// An item is taken when valid is high and stall is low on its channel.
// An accepted byte passes the input register and then the result queue. One
// item is taken every cycle while the queue has room; an accepted header gives
// three results at once, which a small result queue spreads out, so req_stall
// rises only when that queue cannot take a full burst of three.
// When rsp_stall is held, results collect in the queue and then the input
// register holds its item and req_stall is raised; nothing is dropped.
// The csr port writes min_data_len, max_data_len, cmd_min and cmd_max (index
// 0 to 3); write it only while the block is idle.
// Reset restores the register defaults (2, 1026, 0, 255), empties the queue
// and starts hunting for a header.
`default_nettype none

module length_prefixed_frame_deframer #(
   parameter int CRC_BYTES = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_first,
   output logic             rsp_last,
   output logic [31:0]      rsp_frame_index,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   lpfd_pkg::cfg_type      cfg_ff, cfg_in;
   logic                   stage_valid_ff, stage_valid_in;
   logic                   stage_op_ff;
   logic [7:0]             stage_byte_ff;
   logic                   step, req_take, rsp_pop, has_room, not_empty;
   lpfd_pkg::push_type     push;
   lpfd_pkg::rsp_item_type head;

   assign step      = stage_valid_ff && has_room;
   assign req_stall = stage_valid_ff && !has_room;
   assign req_take  = req_valid && !req_stall;
   assign rsp_pop   = not_empty && !rsp_stall;

   assign stage_valid_in = req_take ? 1'b1 : (step ? 1'b0 : stage_valid_ff);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            lpfd_pkg::CSR_MIN_DATA_LEN: cfg_in.min_data_len = csr_write_data;
            lpfd_pkg::CSR_MAX_DATA_LEN: cfg_in.max_data_len = csr_write_data;
            lpfd_pkg::CSR_CMD_MIN:      cfg_in.cmd_min      = csr_write_data[7:0];
            lpfd_pkg::CSR_CMD_MAX:      cfg_in.cmd_max      = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff      <= 1'b0;
         cfg_ff.min_data_len <= lpfd_pkg::MIN_DATA_LEN_RESET;
         cfg_ff.max_data_len <= lpfd_pkg::MAX_DATA_LEN_RESET;
         cfg_ff.cmd_min      <= lpfd_pkg::CMD_MIN_RESET;
         cfg_ff.cmd_max      <= lpfd_pkg::CMD_MAX_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         cfg_ff         <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_op_ff   <= req_op;
         stage_byte_ff <= req_data_byte;
      end
   end

   lpfd_parser #(
      .CRC_BYTES (CRC_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .op        (stage_op_ff),
      .data_byte (stage_byte_ff),
      .cfg       (cfg_ff),
      .push      (push)
   );

   lpfd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_pop),
      .head      (head),
      .not_empty (not_empty),
      .has_room  (has_room)
   );

   assign rsp_valid       = not_empty;
   assign rsp_out_byte    = head.out_byte;
   assign rsp_first       = head.first;
   assign rsp_last        = head.last;
   assign rsp_frame_index = head.frame_index;

endmodule

`default_nettype wire

[dv/length_prefixed_frame_deframer_tb.sv]
`default_nettype none

module length_prefixed_frame_deframer_tb;

   localparam int CRC_LEN      = 2;
   localparam int SETTLE_TICKS = 12;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = lpfd_pkg::OP_BYTE;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_first;
   logic        rsp_last;
   logic [31:0] rsp_frame_index;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = lpfd_pkg::CSR_MIN_DATA_LEN;
   logic [15:0] csr_write_data = 16'h0000;

   length_prefixed_frame_deframer #(
      .CRC_BYTES(CRC_LEN)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_first(rsp_first),
      .rsp_last(rsp_last),
      .rsp_frame_index(rsp_frame_index),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Predicted parser state and register copy.
   lpfd_pkg::cfg_type      cfg_now;
   logic [7:0]             hdr_window [lpfd_pkg::HDR_LEN];
   int                     win_fill;
   int                     body_left;
   lpfd_pkg::mode_type     parse_mode;
   logic [31:0]            cur_index;
   lpfd_pkg::rsp_item_type frame_bytes_due [$];

   int                     mismatch_count = 0;
   int                     items_sent = 0;
   int                     send_idle_pct = 0;
   int                     stall_pct = 0;
   int unsigned            cycle_count = 0;
   lpfd_pkg::rsp_item_type want;

   task automatic report_mismatch(string what);
      $display("ERROR at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic bit rand_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic void clear_parser();
      for (int i = 0; i < lpfd_pkg::HDR_LEN; i++) hdr_window[i] = 8'h00;
      win_fill = 0;
      body_left = 0;
      parse_mode = lpfd_pkg::MODE_HUNT;
      cur_index = 32'h0;
   endfunction

   function automatic void slide_window();
      for (int i = 0; i < lpfd_pkg::HDR_LEN - 1; i++) hdr_window[i] = hdr_window[i + 1];
      hdr_window[lpfd_pkg::HDR_LEN - 1] = 8'h00;
      if (win_fill > 0) win_fill--;
   endfunction

   function automatic void due_byte(logic [7:0] b, logic f, logic l);
      lpfd_pkg::rsp_item_type r;
      r.out_byte = b;
      r.first = f;
      r.last = l;
      r.frame_index = cur_index;
      frame_bytes_due.push_back(r);
   endfunction

   function automatic void hunt_byte(logic [7:0] b);
      logic [15:0] len;
      logic [7:0]  cmd;
      if (win_fill >= lpfd_pkg::HDR_LEN) slide_window();
      hdr_window[win_fill] = b;
      win_fill++;
      while (win_fill >= lpfd_pkg::HDR_LEN - 1) begin
         len = {hdr_window[lpfd_pkg::LEN_POS], hdr_window[lpfd_pkg::LEN_POS + 1]};
         if (len == 16'd0 || len < cfg_now.min_data_len
             || len > cfg_now.max_data_len) begin
            slide_window();
            continue;
         end
         if (win_fill < lpfd_pkg::HDR_LEN) break;
         cmd = hdr_window[lpfd_pkg::CMD_POS];
         if (cmd < cfg_now.cmd_min || cmd > cfg_now.cmd_max) begin
            slide_window();
            continue;
         end
         cur_index = 32'h0;
         for (int i = 0; i < lpfd_pkg::INDEX_BYTES; i++)
            cur_index = {cur_index[23:0], hdr_window[i]};
         body_left = int'(len) - 1 + CRC_LEN;
         due_byte(hdr_window[lpfd_pkg::LEN_POS], 1'b1, 1'b0);
         due_byte(hdr_window[lpfd_pkg::LEN_POS + 1], 1'b0, 1'b0);
         due_byte(cmd, 1'b0, body_left == 0);
         if (body_left == 0) begin
            parse_mode = lpfd_pkg::MODE_AFTER;
         end else begin
            parse_mode = lpfd_pkg::MODE_BODY;
         end
         for (int i = 0; i < lpfd_pkg::HDR_LEN; i++) hdr_window[i] = 8'h00;
         win_fill = 0;
         return;
      end
   endfunction

   function automatic void deframe_byte(logic op, logic [7:0] b);
      if (op == lpfd_pkg::OP_CLEAR) begin
         clear_parser();
         return;
      end
      if (parse_mode == lpfd_pkg::MODE_BODY) begin
         if (body_left > 0) body_left--;
         due_byte(b, 1'b0, body_left == 0);
         if (body_left == 0) parse_mode = lpfd_pkg::MODE_AFTER;
         return;
      end
      if (parse_mode == lpfd_pkg::MODE_AFTER) begin
         parse_mode = lpfd_pkg::MODE_HUNT;
         // A single newline right after a frame is swallowed.
         if (b == lpfd_pkg::NL_BYTE) return;
      end
      parse_mode = lpfd_pkg::MODE_HUNT;
      hunt_byte(b);
   endfunction

   // Result checker, receiver stall generator and cycle counter.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_bytes_due.size() == 0) begin
            report_mismatch($sformatf("result byte %02h with nothing expected", rsp_out_byte));
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_out_byte, want.out_byte));
            if (rsp_first !== want.first)
               report_mismatch($sformatf("first %b, expected %b", rsp_first, want.first));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, expected %b", rsp_last, want.last));
            if (rsp_frame_index !== want.frame_index)
               report_mismatch($sformatf("frame_index %08h, expected %08h",
                                         rsp_frame_index, want.frame_index));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("ERROR: no completion after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
   endtask

   task automatic send_item(logic op, logic [7:0] b);
      int gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      deframe_byte(op, b);
      items_sent++;
   endtask

   // Holds the sender off until every predicted byte has come out.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic apply_config(logic [15:0] min_len, logic [15:0] max_len,
                               logic [7:0] cmd_lo, logic [7:0] cmd_hi);
      drain_results();
      csr_write <= 1'b1;
      csr_index <= lpfd_pkg::CSR_MIN_DATA_LEN;
      csr_write_data <= min_len;
      @(posedge clock);
      csr_index <= lpfd_pkg::CSR_MAX_DATA_LEN;
      csr_write_data <= max_len;
      @(posedge clock);
      csr_index <= lpfd_pkg::CSR_CMD_MIN;
      csr_write_data <= {8'h00, cmd_lo};
      @(posedge clock);
      csr_index <= lpfd_pkg::CSR_CMD_MAX;
      csr_write_data <= {8'h00, cmd_hi};
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_now.min_data_len = min_len;
      cfg_now.max_data_len = max_len;
      cfg_now.cmd_min = cmd_lo;
      cfg_now.cmd_max = cmd_hi;
   endtask

   function automatic logic [15:0] pick_len();
      int lo;
      int hi;
      lo = (cfg_now.min_data_len == 16'd0) ? 1 : int'(cfg_now.min_data_len);
      hi = int'(cfg_now.max_data_len);
      if (lo > hi) return 16'($urandom_range(16, 1));
      if (hi <= 64 && $urandom_range(3) == 0) return 16'(hi);
      return 16'(lo) + 16'($urandom_range((hi - lo > 12) ? 12 : hi - lo, 0));
   endfunction

   function automatic logic [15:0] pick_bad_len();
      if (cfg_now.max_data_len != 16'hFFFF && $urandom_range(1) == 1)
         return 16'($urandom_range(65535, int'(cfg_now.max_data_len) + 1));
      if (cfg_now.min_data_len > 16'd1)
         return 16'($urandom_range(int'(cfg_now.min_data_len) - 1, 0));
      return 16'd0;
   endfunction

   function automatic logic [7:0] pick_cmd();
      if (cfg_now.cmd_min > cfg_now.cmd_max) return rand_byte();
      return 8'($urandom_range(cfg_now.cmd_max, cfg_now.cmd_min));
   endfunction

   function automatic logic [7:0] pick_bad_cmd();
      if (cfg_now.cmd_max != 8'hFF && $urandom_range(1) == 1)
         return 8'($urandom_range(255, int'(cfg_now.cmd_max) + 1));
      if (cfg_now.cmd_min != 8'h00)
         return 8'($urandom_range(int'(cfg_now.cmd_min) - 1, 0));
      return 8'hFF;
   endfunction

   task automatic send_header(logic [31:0] idx, logic [15:0] len, logic [7:0] cmd);
      for (int i = lpfd_pkg::INDEX_BYTES - 1; i >= 0; i--)
         send_item(lpfd_pkg::OP_BYTE, idx[i*8 +: 8]);
      send_item(lpfd_pkg::OP_BYTE, len[15:8]);
      send_item(lpfd_pkg::OP_BYTE, len[7:0]);
      send_item(lpfd_pkg::OP_BYTE, cmd);
   endtask

   task automatic send_frame(logic [31:0] idx, logic [15:0] len, logic [7:0] cmd,
                             bit add_newline);
      send_header(idx, len, cmd);
      repeat (int'(len) - 1 + CRC_LEN) send_item(lpfd_pkg::OP_BYTE, rand_byte());
      if (add_newline) send_item(lpfd_pkg::OP_BYTE, lpfd_pkg::NL_BYTE);
   endtask

   // Mostly well-formed frames, with rejected headers, noise, cut-off frames
   // and clears mixed in.
   task automatic random_traffic(int count);
      int          stop;
      int          kind;
      logic [15:0] len;
      stop = items_sent + count;
      while (items_sent < stop) begin
         kind = $urandom_range(99);
         if (kind < 60) begin
            send_frame($urandom, pick_len(), pick_cmd(), rand_bit());
         end else if (kind < 72) begin
            if ((cfg_now.cmd_min != 8'h00 || cfg_now.cmd_max != 8'hFF) &&
                $urandom_range(1) == 1) begin
               send_header($urandom, pick_len(), pick_bad_cmd());
            end else begin
               send_header($urandom, pick_bad_len(), rand_byte());
            end
            send_frame($urandom, pick_len(), pick_cmd(), rand_bit());
         end else if (kind < 84) begin
            repeat ($urandom_range(8, 1)) send_item(lpfd_pkg::OP_BYTE, rand_byte());
            // Wide length limits let noise open a huge false frame, so clear it.
            if (cfg_now.max_data_len > 16'd1026 || $urandom_range(1) == 1)
               send_item(lpfd_pkg::OP_CLEAR, rand_byte());
         end else if (kind < 94) begin
            len = pick_len();
            send_header($urandom, len, pick_cmd());
            repeat ($urandom_range(int'(len) - 2 + CRC_LEN, 0))
               send_item(lpfd_pkg::OP_BYTE, rand_byte());
            send_item(lpfd_pkg::OP_CLEAR, rand_byte());
         end else begin
            send_item(lpfd_pkg::OP_CLEAR, rand_byte());
         end
      end
   endtask

   task automatic test_default_frames();
      set_idling(0, 0);
      send_frame(32'hFFFF_FFFF, 16'd2, 8'h00, 1'b1);
      // A zero length never passes, even after several slides.
      repeat (5) send_item(lpfd_pkg::OP_BYTE, 8'h00);
      send_item(lpfd_pkg::OP_CLEAR, 8'hFF);
      send_frame(32'h0000_0000, 16'd3, 8'hFF, 1'b0);
      send_item(lpfd_pkg::OP_BYTE, 8'hA5);
      send_item(lpfd_pkg::OP_CLEAR, 8'h00);
      random_traffic(40);
   endtask

   task automatic test_wide_limits();
      apply_config(16'd1, 16'hFFFF, 8'h00, 8'hFF);
      set_idling(81, 0);
      send_frame($urandom, 16'd1, rand_byte(), 1'b1);
      random_traffic(40);
   endtask

   task automatic test_narrow_ranges();
      apply_config(16'd0, 16'd8, 8'd16, 8'd32);
      set_idling(0, 81);
      send_header(32'h1234_5678, 16'd0, 8'd16);
      send_item(lpfd_pkg::OP_CLEAR, 8'h00);
      send_header($urandom, 16'd8, 8'd33);
      send_item(lpfd_pkg::OP_CLEAR, 8'h00);
      send_frame($urandom, 16'd1, 8'd16, 1'b0);
      send_frame($urandom, 16'd8, 8'd32, 1'b1);
      random_traffic(40);
   endtask

   task automatic test_extreme_limits();
      set_idling(7, 7);
      apply_config(16'd20, 16'd10, 8'h00, 8'hFF);
      random_traffic(10);
      apply_config(16'd2, 16'd1026, 8'd200, 8'd100);
      random_traffic(10);
      apply_config(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
      send_header(32'h0, 16'hFFFF, 8'hFE);
      send_header(32'h0, 16'hFFFE, 8'hFF);
      send_item(lpfd_pkg::OP_CLEAR, 8'h00);
      apply_config(16'd1, 16'd1, 8'h00, 8'h00);
      random_traffic(20);
   endtask

   task automatic test_pause_midstream();
      apply_config(16'd3, 16'd40, 8'd1, 8'd254);
      set_idling(81, 0);
      random_traffic(25);
      drain_results();
      set_idling(7, 7);
      random_traffic(15);
   endtask

   initial begin
      cfg_now.min_data_len = lpfd_pkg::MIN_DATA_LEN_RESET;
      cfg_now.max_data_len = lpfd_pkg::MAX_DATA_LEN_RESET;
      cfg_now.cmd_min = lpfd_pkg::CMD_MIN_RESET;
      cfg_now.cmd_max = lpfd_pkg::CMD_MAX_RESET;
      clear_parser();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_default_frames();
      test_wide_limits();
      test_narrow_ranges();
      test_extreme_limits();
      test_pause_midstream();
      drain_results();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
